[rtl/core/neighbour_discovery_table_core_assert.svh]
// Assertion helpers for the neighbour discovery table.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef NEIGHBOUR_DISCOVERY_TABLE_CORE_ASSERT_SVH
`define NEIGHBOUR_DISCOVERY_TABLE_CORE_ASSERT_SVH

// Same-cycle implication.
`define NDT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("neighbour table check failed");

// Next-cycle implication.
`define NDT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("neighbour table check failed");

`endif

[rtl/core/ndt_pkg.sv]
`timescale 1ns / 1ps

package ndt_pkg;

  typedef enum logic [1:0] {
    ACT_PACKET   = 2'd0,
    ACT_QUERY    = 2'd1,
    ACT_DISCOVER = 2'd2,
    ACT_TICK     = 2'd3
  } action_e;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_TRIES  = 3'd4;

  localparam logic        RST_ENABLE       = 1'b1;
  localparam logic [15:0] RST_TIMEOUT      = 16'd640;
  localparam logic [15:0] RST_SWEEP_PERIOD = 16'd640;
  localparam logic [15:0] RST_RETRY_PERIOD = 16'd25;
  localparam logic [3:0]  RST_RETRY_TRIES  = 4'd5;

  // 13-byte discovery tag and 8-byte here tag in ASCII, byte 0 in the low bits
  localparam logic [63:0] TAG_DISC_HEAD = 64'h4353_4944_5F4E_5444;
  localparam logic [39:0] TAG_DISC_TAIL = 40'h59_5245_564F;
  localparam logic [63:0] TAG_HERE      = 64'h4552_4548_5F4E_5444;

  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic commit;
  } ndt_cmd_t;

  typedef struct packed {
    logic rd_last;
  } ndt_status_t;

endpackage

[rtl/core/ndt_ctrl.sv]
`timescale 1ns / 1ps

module ndt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  output logic                done_o,
  output ndt_pkg::ndt_cmd_t   cmd_o,
  input  ndt_pkg::ndt_status_t status_i
);
  import ndt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) state_q <= ST_READ;
        end
        ST_READ: begin
          if (status_i.rd_last) state_q <= ST_DRAIN;
        end
        // last slot is evaluated here
        ST_DRAIN: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.capture = (state_q == ST_IDLE) && start_i;
    cmd_o.scan_rd = (state_q == ST_READ);
    cmd_o.commit  = (state_q == ST_COMMIT);
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

[rtl/core/ndt_datapath.sv]
`timescale 1ns / 1ps

module ndt_datapath #(
  parameter int unsigned ENTRIES = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ndt_pkg::ndt_cmd_t              cmd_i,
  output ndt_pkg::ndt_status_t           status_o,
  input  logic                           cfg_valid_i,
  input  logic [ndt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [15:0]                    cfg_data_i,
  input  logic [1:0]                     action_i,
  input  logic [15:0]                    peer_addr_i,
  input  logic [63:0]                    payload_head_i,
  input  logic [39:0]                    payload_tail_i,
  output logic                           known_o,
  output logic                           send_discovery_o,
  output logic                           send_reply_o,
  output logic                           beacon_found_o,
  output logic [15:0]                    out_addr_o,
  output logic                           evicted_o,
  output logic [1:0]                     timed_out_count_o
);
  import ndt_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // configuration
  logic        enable_q;
  logic [15:0] timeout_q;
  logic [15:0] sweep_period_q;
  logic [15:0] retry_period_q;
  logic [3:0]  retry_tries_q;

  // time and retry state
  logic [31:0] now_q;
  logic [15:0] sweep_cnt_q;
  logic [15:0] retry_cnt_q;
  logic [4:0]  pend_q;

  // captured item
  action_e     act_q;
  logic [15:0] peer_q;
  logic        disc_tag_q;
  logic        here_tag_q;
  logic        sweep_q;
  logic        tick_sdisc_q;

  // slot storage
  logic [ENTRIES-1:0] valid_q;
  logic [IW-1:0]      order_q [ENTRIES];
  logic [15:0]        addr_mem [ENTRIES];
  logic [31:0]        stamp_mem [ENTRIES];
  logic [15:0]        addr_rd_q;
  logic [31:0]        stamp_rd_q;

  // scan
  logic [IW-1:0] idx_q;
  logic          eval_v_q;
  logic [IW-1:0] eval_idx_q;
  logic          hit_q;
  logic [IW-1:0] hit_idx_q;
  logic          free_q;
  logic [IW-1:0] free_idx_q;
  logic          old_any_q;
  logic [IW-1:0] old_idx_q;
  logic [31:0]   best_age_q;
  logic [IW-1:0] best_ord_q;
  logic [CW-1:0] cnt_q;
  logic [1:0]    timed_q;

  logic [15:0] sweep_inc;
  logic        sweep_hit;
  logic [15:0] retry_inc;
  logic        retry_hit;
  logic [4:0]  pend_inc;
  logic        pend_over;
  logic        is_tick_in;

  logic          ev_valid;
  logic [IW-1:0] ev_ord;
  logic [31:0]   age;
  logic          is_hit;
  logic          older;
  logic          expire;

  logic          pkt_commit;
  logic          refresh;
  logic          ins;
  logic          evict;
  logic [IW-1:0] ins_idx;
  logic [IW-1:0] ins_ord;
  logic [IW-1:0] wr_idx;
  logic          drop_en;
  logic [IW-1:0] drop_idx;
  logic [IW-1:0] drop_ord;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q       <= RST_ENABLE;
      timeout_q      <= RST_TIMEOUT;
      sweep_period_q <= RST_SWEEP_PERIOD;
      retry_period_q <= RST_RETRY_PERIOD;
      retry_tries_q  <= RST_RETRY_TRIES;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ENABLE:       enable_q       <= cfg_data_i[0];
        CFG_TIMEOUT:      timeout_q      <= cfg_data_i;
        CFG_SWEEP_PERIOD: sweep_period_q <= cfg_data_i;
        CFG_RETRY_PERIOD: retry_period_q <= cfg_data_i;
        CFG_RETRY_TRIES:  retry_tries_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    is_tick_in = (action_i == ACT_TICK);
    sweep_inc  = sweep_cnt_q + 16'd1;
    sweep_hit  = (sweep_inc >= sweep_period_q);
    retry_inc  = retry_cnt_q + 16'd1;
    retry_hit  = (pend_q != 5'd0) && (retry_inc >= retry_period_q);
    pend_inc   = pend_q + 5'd1;
    pend_over  = (pend_inc > ({1'b0, retry_tries_q} + 5'd1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      sweep_cnt_q <= '0;
      retry_cnt_q <= '0;
      pend_q      <= '0;
    end else if (cmd_i.capture && is_tick_in) begin
      now_q       <= now_q + 32'd1;
      sweep_cnt_q <= sweep_hit ? 16'd0 : sweep_inc;
      if (pend_q != 5'd0) begin
        if (retry_hit) begin
          retry_cnt_q <= '0;
          pend_q      <= pend_over ? 5'd0 : pend_inc;
        end else begin
          retry_cnt_q <= retry_inc;
        end
      end
    end else if (cmd_i.commit) begin
      // a here beat ends the retries, a discover miss restarts them
      if (act_q == ACT_PACKET && !disc_tag_q && here_tag_q) begin
        pend_q      <= '0;
        retry_cnt_q <= '0;
      end else if (act_q == ACT_DISCOVER && !hit_q) begin
        pend_q      <= 5'd1;
        retry_cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q        <= action_e'(action_i);
      peer_q       <= peer_addr_i;
      disc_tag_q   <= (payload_head_i == TAG_DISC_HEAD) && (payload_tail_i == TAG_DISC_TAIL);
      here_tag_q   <= (payload_head_i == TAG_HERE);
      sweep_q      <= is_tick_in && sweep_hit;
      tick_sdisc_q <= is_tick_in && retry_hit && enable_q;
    end
  end

  // scan pointer: read slot idx_q, evaluate it in the following cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      eval_v_q   <= 1'b0;
      eval_idx_q <= '0;
    end else begin
      if (cmd_i.capture) begin
        idx_q <= '0;
      end else if (cmd_i.scan_rd) begin
        idx_q <= idx_q + IW'(1);
      end
      eval_v_q   <= cmd_i.scan_rd;
      eval_idx_q <= idx_q;
    end
  end

  assign status_o.rd_last = (idx_q == LAST_IDX);

  always_comb begin
    ev_valid = valid_q[eval_idx_q];
    ev_ord   = order_q[eval_idx_q];
    age      = now_q - stamp_rd_q;
    is_hit   = ev_valid && (addr_rd_q == peer_q);
    older    = !old_any_q || (age > best_age_q) ||
               ((age == best_age_q) && (ev_ord < best_ord_q));
    expire   = sweep_q && ev_valid && (age > {16'd0, timeout_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      old_any_q  <= 1'b0;
      old_idx_q  <= '0;
      best_age_q <= '0;
      best_ord_q <= '0;
      cnt_q      <= '0;
      timed_q    <= '0;
    end else if (cmd_i.capture) begin
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      old_any_q <= 1'b0;
      cnt_q     <= '0;
      timed_q   <= '0;
    end else if (eval_v_q) begin
      if (is_hit && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= eval_idx_q;
      end
      if (!ev_valid && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= eval_idx_q;
      end
      if (ev_valid) cnt_q <= cnt_q + CW'(1);
      // ties go to the lower insertion rank
      if (older) begin
        old_any_q  <= 1'b1;
        old_idx_q  <= eval_idx_q;
        best_age_q <= age;
        best_ord_q <= ev_ord;
      end
      if (expire && timed_q != 2'd3) timed_q <= timed_q + 2'd1;
    end
  end

  always_comb begin
    pkt_commit = cmd_i.commit && (act_q == ACT_PACKET);
    refresh    = pkt_commit && hit_q;
    ins        = pkt_commit && !hit_q;
    evict      = ins && !free_q;
    ins_idx    = free_q ? free_idx_q : old_idx_q;
    ins_ord    = free_q ? IW'(cnt_q) : LAST_IDX;
    wr_idx     = hit_q ? hit_idx_q : ins_idx;
    drop_en    = (eval_v_q && expire) || evict;
    drop_idx   = evict ? old_idx_q : eval_idx_q;
    drop_ord   = evict ? best_ord_q : ev_ord;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (drop_en && drop_idx == IW'(i)) valid_q[i] <= 1'b0;
        if (ins && ins_idx == IW'(i)) valid_q[i] <= 1'b1;
      end
    end
  end

  // keep ranks compact: close the gap left by a dropped slot
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (drop_en && valid_q[i] && order_q[i] > drop_ord) order_q[i] <= order_q[i] - IW'(1);
      if (ins && ins_idx == IW'(i)) order_q[i] <= ins_ord;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins) addr_mem[ins_idx] <= peer_q;
    if (refresh || ins) stamp_mem[wr_idx] <= now_q;
    if (cmd_i.scan_rd) begin
      addr_rd_q  <= addr_mem[idx_q];
      stamp_rd_q <= stamp_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      known_o           <= 1'b0;
      send_discovery_o  <= 1'b0;
      send_reply_o      <= 1'b0;
      beacon_found_o    <= 1'b0;
      out_addr_o        <= '0;
      evicted_o         <= 1'b0;
      timed_out_count_o <= '0;
      case (act_q)
        ACT_PACKET: begin
          evicted_o <= !hit_q && !free_q;
          if (disc_tag_q) begin
            send_reply_o <= enable_q;
            if (enable_q) out_addr_o <= peer_q;
          end else if (here_tag_q) begin
            beacon_found_o <= 1'b1;
            out_addr_o     <= peer_q;
          end
        end
        ACT_QUERY: begin
          known_o <= hit_q;
        end
        ACT_DISCOVER: begin
          known_o          <= hit_q;
          send_discovery_o <= !hit_q && enable_q;
        end
        ACT_TICK: begin
          send_discovery_o  <= tick_sdisc_q;
          timed_out_count_o <= timed_q;
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/neighbour_discovery_table_core.sv]
`timescale 1ns / 1ps
`include "neighbour_discovery_table_core_assert.svh"

// Neighbour cache with oldest-entry eviction and timeout sweeps.
// Command channel: an item (action_i, peer_addr_i, payload_head_i,
// payload_tail_i) is taken at a rising edge with start high and busy low.
// Actions: received packet, address query, discover request, one tick.
// Each item gives exactly one result, shown for one cycle with done_o high;
// the receiver cannot stall it. A new item may be started in the same cycle
// that done_o shows the previous result.
// Sequence: after the accepting edge the controller steps through READ,
// DRAIN and COMMIT and then raises done_o; busy stays high throughout, so
// no new item is taken before done_o shows the previous result. READ scans
// the slots, one slot per cycle through the address/stamp memory read port.
// Configuration: cfg_valid_i with cfg_index_i/cfg_data_i, always ready;
// write only while busy is low and no result is pending.
// Reset: cache empty, time and retry counters zero, registers at defaults;
// no clearing pass, the first item may start right after reset.
module neighbour_discovery_table_core #(
  parameter int unsigned ENTRIES = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ndt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic [1:0]                    action_i,
  input  logic [15:0]                   peer_addr_i,
  input  logic [63:0]                   payload_head_i,
  input  logic [39:0]                   payload_tail_i,
  output logic                          done_o,
  output logic                          known_o,
  output logic                          send_discovery_o,
  output logic                          send_reply_o,
  output logic                          beacon_found_o,
  output logic [15:0]                   out_addr_o,
  output logic                          evicted_o,
  output logic [1:0]                    timed_out_count_o
);
  import ndt_pkg::*;

  ndt_cmd_t    cmd;
  ndt_status_t status;

  assign cfg_ready_o = 1'b1;

  ndt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .done_o   (done_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  ndt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .action_i          (action_i),
    .peer_addr_i       (peer_addr_i),
    .payload_head_i    (payload_head_i),
    .payload_tail_i    (payload_tail_i),
    .known_o           (known_o),
    .send_discovery_o  (send_discovery_o),
    .send_reply_o      (send_reply_o),
    .beacon_found_o    (beacon_found_o),
    .out_addr_o        (out_addr_o),
    .evicted_o         (evicted_o),
    .timed_out_count_o (timed_out_count_o)
  );

  `NDT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `NDT_ASSERT_IMPLY(a_done_idle, done_o, !busy)
  `NDT_ASSERT_NEXT(a_single_done, done_o, !done_o)
  `NDT_ASSERT_IMPLY(a_reply_found_excl, done_o, !(send_reply_o && beacon_found_o))

endmodule
